// ===== rtl/tcw_pkg.sv =====
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types and constants of the text console writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

    localparam int COLUMNS_DEF = 80;
    localparam int ROWS_DEF    = 25;

    localparam logic [7:0] BLANK_CHAR     = 8'h20;
    localparam logic [7:0] RESET_ATTR     = 8'h07;
    localparam logic [7:0] BYTE_NEWLINE   = 8'h0A;
    localparam logic [7:0] BYTE_BACKSPACE = 8'h08;

    localparam logic MODE_PUT  = 1'b0;
    localparam logic MODE_READ = 1'b1;

    typedef struct packed {
        logic        mode;
        logic [7:0]  char_byte;
        logic [10:0] cell_index;
    } t_in_beat;

    typedef struct packed {
        logic [7:0] cell_char;
        logic [7:0] cell_attr;
        logic [4:0] cursor_row_now;
        logic [6:0] cursor_col_now;
        logic       did_scroll;
    } t_out_beat;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_MOVE,
        ST_BLANK,
        ST_RESP
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic accept;
        logic put;
        logic move_step;
        logic blank_step;
        logic clear_step;
        logic out_load;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic scroll_req;
        logic ptr_move_end;
        logic ptr_last;
    } t_status;

endpackage

// ===== rtl/tcw_ctrl.sv =====
// ----------------------------------------------------------------------------
// tcw_ctrl
// Sequencer of the console writer: clear pass, item handling, scroll sweep
// and the output beat register handshake.
// ----------------------------------------------------------------------------
module tcw_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    input  tcw_pkg::t_status i_status,
    output tcw_pkg::t_cmd    o_cmd
);

    tcw_pkg::t_state r_state;
    tcw_pkg::t_state n_state;
    logic            r_out_valid;
    logic            n_out_valid;
    logic            out_free;

    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tcw_pkg::ST_CLEAR: begin
                if (i_status.ptr_last) n_state = tcw_pkg::ST_IDLE;
            end
            tcw_pkg::ST_IDLE: begin
                if (i_in_valid) n_state = tcw_pkg::ST_EXEC;
            end
            tcw_pkg::ST_EXEC: begin
                n_state = i_status.scroll_req ? tcw_pkg::ST_MOVE : tcw_pkg::ST_RESP;
            end
            tcw_pkg::ST_MOVE: begin
                if (i_status.ptr_move_end) n_state = tcw_pkg::ST_BLANK;
            end
            tcw_pkg::ST_BLANK: begin
                if (i_status.ptr_last) n_state = tcw_pkg::ST_RESP;
            end
            tcw_pkg::ST_RESP: begin
                if (out_free) n_state = tcw_pkg::ST_IDLE;
            end
            default: n_state = tcw_pkg::ST_CLEAR;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            tcw_pkg::ST_CLEAR: o_cmd.clear_step = 1'b1;
            tcw_pkg::ST_IDLE: begin
                o_in_stall   = 1'b0;
                o_cmd.accept = i_in_valid;
            end
            tcw_pkg::ST_EXEC:  o_cmd.put        = 1'b1;
            tcw_pkg::ST_MOVE:  o_cmd.move_step  = 1'b1;
            tcw_pkg::ST_BLANK: o_cmd.blank_step = 1'b1;
            tcw_pkg::ST_RESP:  o_cmd.out_load   = out_free;
            default: o_cmd = '0;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) n_out_valid = 1'b1;
        else if (!i_out_stall) n_out_valid = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tcw_pkg::ST_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// ===== rtl/tcw_datapath.sv =====
// ----------------------------------------------------------------------------
// tcw_datapath
// Cell store, cursor, sweep pointer, attribute register and result register.
// ----------------------------------------------------------------------------
module tcw_datapath #(
    parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
    parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  tcw_pkg::t_in_beat  i_in_beat,
    input  logic               i_cfg_valid,
    input  logic [7:0]         i_cfg_data,
    input  tcw_pkg::t_cmd      i_cmd,
    output tcw_pkg::t_status   o_status,
    output tcw_pkg::t_out_beat o_out_beat
);

    localparam int CELL_COUNT = ROWS * COLUMNS;
    localparam int MOVE_COUNT = CELL_COUNT - COLUMNS;
    localparam int ADDR_W     = $clog2(CELL_COUNT);
    localparam int COL_W      = $clog2(COLUMNS);
    localparam int ROW_W      = $clog2(ROWS);

    logic [15:0]       mem [CELL_COUNT];
    logic [15:0]       r_rd_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [15:0]       wr_data;

    logic [7:0]        r_attr;
    logic              r_mode;
    logic [7:0]        r_char;
    logic              r_rd_ok;
    logic [ROW_W-1:0]  r_row;
    logic [ROW_W-1:0]  n_row;
    logic [COL_W-1:0]  r_col;
    logic [COL_W-1:0]  n_col;
    logic              r_scrolled;
    logic              n_scrolled;
    logic [ADDR_W-1:0] r_ptr;
    logic [ADDR_W-1:0] n_ptr;
    tcw_pkg::t_out_beat r_out;

    logic [31:0]       idx32;
    logic [31:0]       row32;
    logic [31:0]       col32;
    logic [ADDR_W:0]   src_addr;
    logic [ADDR_W-1:0] cur_addr;
    logic              col_last;
    logic              row_last;
    logic              advance;

    assign idx32    = 32'(i_in_beat.cell_index);
    assign row32    = 32'(r_row);
    assign col32    = 32'(r_col);
    assign src_addr = {1'b0, r_ptr} + (ADDR_W + 1)'(COLUMNS);
    assign cur_addr = ADDR_W'(ADDR_W'(r_row) * ADDR_W'(COLUMNS)) + ADDR_W'(r_col);
    assign col_last = (r_col == COL_W'(COLUMNS - 1));
    assign row_last = (r_row == ROW_W'(ROWS - 1));

    // cursor update and store port selection
    always_comb begin
        rd_en      = 1'b0;
        rd_addr    = idx32[ADDR_W-1:0];
        wr_en      = 1'b0;
        wr_addr    = r_ptr;
        wr_data    = {r_attr, tcw_pkg::BLANK_CHAR};
        n_row      = r_row;
        n_col      = r_col;
        n_scrolled = r_scrolled;
        n_ptr      = r_ptr;
        advance    = 1'b0;

        if (i_cmd.accept) begin
            rd_en      = (i_in_beat.mode == tcw_pkg::MODE_READ);
            n_scrolled = 1'b0;
        end

        if (i_cmd.put && r_mode == tcw_pkg::MODE_PUT) begin
            if (r_char == tcw_pkg::BYTE_NEWLINE) begin
                advance = 1'b1;
            end else if (r_char == tcw_pkg::BYTE_BACKSPACE) begin
                if (r_col != '0) begin
                    n_col   = r_col - 1'b1;
                    wr_en   = 1'b1;
                    wr_addr = cur_addr - 1'b1;
                end
            end else begin
                wr_en   = 1'b1;
                wr_addr = cur_addr;
                wr_data = {r_attr, r_char};
                if (col_last) advance = 1'b1;
                else n_col = r_col + 1'b1;
            end
            if (advance) begin
                n_col = '0;
                if (row_last) begin
                    n_scrolled = 1'b1;
                    n_ptr      = '0;
                end else begin
                    n_row = r_row + 1'b1;
                end
            end
        end

        // copy pipeline: read the cell one row down, write it from the read register in the following step
        if (i_cmd.move_step) begin
            if (r_ptr != ADDR_W'(MOVE_COUNT)) begin
                rd_en   = 1'b1;
                rd_addr = src_addr[ADDR_W-1:0];
                n_ptr   = r_ptr + 1'b1;
            end
            if (r_ptr != '0) begin
                wr_en   = 1'b1;
                wr_addr = r_ptr - 1'b1;
                wr_data = r_rd_data;
            end
        end

        if (i_cmd.blank_step) begin
            wr_en   = 1'b1;
            wr_addr = r_ptr;
            n_ptr   = r_ptr + 1'b1;
        end

        if (i_cmd.clear_step) begin
            wr_en   = 1'b1;
            wr_addr = r_ptr;
            wr_data = {tcw_pkg::RESET_ATTR, tcw_pkg::BLANK_CHAR};
            n_ptr   = r_ptr + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) mem[wr_addr] <= wr_data;
        if (rd_en) r_rd_data <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attr     <= tcw_pkg::RESET_ATTR;
            r_row      <= '0;
            r_col      <= '0;
            r_ptr      <= '0;
            r_scrolled <= 1'b0;
        end else begin
            if (i_cfg_valid) r_attr <= i_cfg_data;
            r_row      <= n_row;
            r_col      <= n_col;
            r_ptr      <= n_ptr;
            r_scrolled <= n_scrolled;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_mode  <= i_in_beat.mode;
            r_char  <= i_in_beat.char_byte;
            r_rd_ok <= (i_in_beat.mode == tcw_pkg::MODE_READ) &&
                       (idx32 < 32'(CELL_COUNT));
        end
        if (i_cmd.out_load) begin
            r_out.cell_char      <= r_rd_ok ? r_rd_data[7:0]  : 8'd0;
            r_out.cell_attr      <= r_rd_ok ? r_rd_data[15:8] : 8'd0;
            r_out.cursor_row_now <= row32[4:0];
            r_out.cursor_col_now <= col32[6:0];
            r_out.did_scroll     <= r_scrolled;
        end
    end

    assign o_status.scroll_req   = n_scrolled && i_cmd.put;
    assign o_status.ptr_move_end = (r_ptr == ADDR_W'(MOVE_COUNT));
    assign o_status.ptr_last     = (r_ptr == ADDR_W'(CELL_COUNT - 1));
    assign o_out_beat            = r_out;

endmodule

// ===== rtl/text_console_writer_core.sv =====
// ----------------------------------------------------------------------------
// text_console_writer_core
// Text console putchar with scroll: a ROWS x COLUMNS cell store and a cursor.
// ----------------------------------------------------------------------------
// Sequence: an accepted beat passes the accept, execute and respond states to
// the output register for reads and plain puts; a put that scrolls adds the
// copy and bottom-row blank sweep before respond, one cell per cycle
// through the single write port of the cell store.
// Flow: a new item is taken only after respond has loaded the output beat.
// Reset: a clearing pass fills the store with blanks;
// input stays stalled meanwhile, configuration writes are taken at once.
module text_console_writer_core #(
    parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
    parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // item input channel
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  tcw_pkg::t_in_beat  i_in_beat,
    // result output channel
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output tcw_pkg::t_out_beat o_out_beat,
    // text_attribute register write
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [7:0]         i_cfg_data
);

    tcw_pkg::t_cmd    cmd;
    tcw_pkg::t_status status;

    // The attribute register takes a write in every cycle outside reset.
    assign o_cfg_ready = 1'b1;

    // Sequencer: owns the state, the input stall and the output valid.
    tcw_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    // Datapath: cell store, cursor, sweep pointer and the result beat.
    tcw_datapath #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_beat   (i_in_beat),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_beat  (o_out_beat)
    );

endmodule
